@@ rtl/bollinger_band_reversion_signal_core_defines.svh @@
// Assertion macros shared by the core.
`ifndef BOLLINGER_BAND_REVERSION_SIGNAL_CORE_DEFINES_SVH
`define BOLLINGER_BAND_REVERSION_SIGNAL_CORE_DEFINES_SVH
`ifndef SYNTH
`define BBRS_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define BBRS_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m: assertion failed");
`else
`define BBRS_ASSERT(label, clk, rst, prop)
`define BBRS_ASSERT_NORST(label, clk, prop)
`endif
`endif

@@ rtl/bbrs_pkg.sv @@
package bbrs_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 64;

   localparam int PRICE_W  = 24;
   localparam int BAR_W    = 32;
   localparam int SIDE_W   = 2;
   localparam int QTY_W    = 32;
   localparam int EQ_W     = 48;
   localparam int WLEN_W   = 7;
   localparam int MULT_W   = 12;
   localparam int FRAC_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int SUM_W    = PRICE_W + WLEN_W;        // n*close and window sum
   localparam int SQSUM_W  = 2 * PRICE_W + WLEN_W;    // window sum of squares
   localparam int VAR_W    = 2 * SUM_W;               // n*Q - S*S
   localparam int M2_W     = 2 * MULT_W;
   localparam int LHS_W    = VAR_W + 16;
   localparam int RHS_W    = VAR_W + M2_W;
   localparam int DVD_W    = EQ_W;                    // (equity*fraction) >> 16

   localparam int MUL_A_W     = VAR_W;
   localparam int MUL_B_W     = 32;
   localparam int MUL_DIGIT_W = 16;
   localparam int MUL_P_W     = MUL_A_W + MUL_B_W;

   localparam logic [SIDE_W-1:0] SIDE_FLAT = 2'd0;
   localparam logic [SIDE_W-1:0] SIDE_LONG = 2'd1;
   localparam logic ORDER_BUY  = 1'b0;
   localparam logic ORDER_SELL = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_MULTIPLIER   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_POSITION_FRACTION = 2'd2;

   localparam logic [WLEN_W-1:0] WINDOW_LENGTH_RESET     = 7'd20;
   localparam logic [MULT_W-1:0] BAND_MULTIPLIER_RESET   = 12'd512;
   localparam logic [FRAC_W-1:0] POSITION_FRACTION_RESET = 16'd6554;

   typedef enum logic [3:0] {
      MUL_CC, MUL_OO, MUL_SS, MUL_NQ, MUL_NC, MUL_MM, MUL_M2, MUL_VM, MUL_EF
   } mul_op_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CC, ST_OO, ST_UPDATE, ST_SS, ST_NQ, ST_NC, ST_MM, ST_M2, ST_VM,
      ST_DECIDE, ST_EF, ST_DIVIDE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       update;
      logic       mul_go;
      mul_op_type mul_op;
      logic       div_go;
      logic       out_load;
      logic       out_sell;
   } cmd_type;

   typedef struct packed {
      logic full_pre;
      logic fill_after;
      logic mul_done;
      logic div_done;
      logic buy;
      logic sell;
      logic qty_zero;
   } status_type;

endpackage

@@ rtl/bbrs_ram.sv @@
module bbrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/bbrs_mul.sv @@
module bbrs_mul import bbrs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [MUL_A_W-1:0] a,
   input  logic [MUL_B_W-1:0] b,
   output logic [MUL_P_W-1:0] prod,
   output logic               done
);
   localparam int STEPS = MUL_B_W / MUL_DIGIT_W;
   localparam int CW    = $clog2(STEPS + 1);
   localparam int PART_W = MUL_A_W + MUL_DIGIT_W;

   logic               running_ff, done_ff;
   logic [CW-1:0]      cnt_ff;
   logic [MUL_A_W-1:0] a_ff;
   logic [MUL_B_W-1:0] b_ff;
   logic [MUL_P_W-1:0] acc_ff, acc_in;
   logic [PART_W-1:0]  part;
   logic               load;

   assign load = !running_ff && !done_ff && go;
   // one digit of the multiplier a cycle, most significant first
   assign part = PART_W'(a_ff) * PART_W'(b_ff[MUL_B_W-1 -: MUL_DIGIT_W]);
   assign acc_in = {acc_ff[MUL_P_W-MUL_DIGIT_W-1:0], MUL_DIGIT_W'(0)} + MUL_P_W'(part);

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            running_ff <= 1'b1;
            cnt_ff     <= CW'(STEPS);
         end else if (running_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (running_ff) begin
         acc_ff <= acc_in;
         b_ff   <= {b_ff[MUL_B_W-MUL_DIGIT_W-1:0], MUL_DIGIT_W'(0)};
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;
endmodule

@@ rtl/bbrs_div.sv @@
module bbrs_div import bbrs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               go,
   input  logic [DVD_W-1:0]   dividend,
   input  logic [PRICE_W-1:0] divisor,
   output logic [DVD_W-1:0]   quotient,
   output logic               done
);
   localparam int CW = $clog2(DVD_W + 1);

   logic               running_ff, done_ff, load, ge;
   logic [CW-1:0]      cnt_ff;
   logic [DVD_W-1:0]   q_ff;
   logic [PRICE_W-1:0] rem_ff, rem_in, d_ff;
   logic [PRICE_W:0]   rem_t;

   assign load  = !running_ff && !done_ff && go;
   assign rem_t = {rem_ff, q_ff[DVD_W-1]};
   assign ge    = rem_t >= {1'b0, d_ff};
   assign rem_in = ge ? PRICE_W'(rem_t - {1'b0, d_ff}) : rem_t[PRICE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         done_ff    <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         done_ff <= 1'b0;
         if (load) begin
            running_ff <= 1'b1;
            cnt_ff     <= CW'(DVD_W);
         end else if (running_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               running_ff <= 1'b0;
               done_ff    <= 1'b1;
            end
         end
      end
   end

   // restoring division, one quotient bit a cycle
   always_ff @(posedge clock) begin
      if (load) begin
         q_ff   <= dividend;
         d_ff   <= divisor;
         rem_ff <= '0;
      end else if (running_ff) begin
         rem_ff <= rem_in;
         q_ff   <= {q_ff[DVD_W-2:0], ge};
      end
   end

   assign quotient = q_ff;
   assign done     = done_ff;
endmodule

@@ rtl/bbrs_dpath.sv @@
module bbrs_dpath import bbrs_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [PRICE_W-1:0]    req_close_price,
   input  logic [BAR_W-1:0]      req_bar_number,
   input  logic [SIDE_W-1:0]     req_position_side,
   input  logic [QTY_W-1:0]      req_held_quantity,
   input  logic [EQ_W-1:0]       req_account_equity,
   output logic                  rsp_order_side,
   output logic [QTY_W-1:0]      rsp_order_quantity,
   output logic [BAR_W-1:0]      rsp_order_bar_number
);
   localparam int AW = $clog2(WINDOW_DEPTH);

   logic [WLEN_W-1:0]  wlen_ff, n_w, count_ff;
   logic [MULT_W-1:0]  mult_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic [AW-1:0]      slot_ff, slot_in;
   logic [SUM_W-1:0]   sum_ff, nc_ff, mag;
   logic [SQSUM_W-1:0] sqsum_ff;

   logic [PRICE_W-1:0] close_ff, old_price;
   logic [BAR_W-1:0]   bar_ff;
   logic [SIDE_W-1:0]  side_ff;
   logic [QTY_W-1:0]   held_ff, qty_ff;
   logic [EQ_W-1:0]    equity_ff;
   logic [2*PRICE_W-1:0] sqnew_ff, sqold_ff;
   logic [VAR_W-1:0]   ss_ff, var_ff, mm_ff;
   logic [M2_W-1:0]    m2_ff;
   logic [DVD_W-1:0]   dvd_ff, quotient;
   logic               hit_ff, below, full_pre;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] prod;
   logic               mul_done, div_done;

   assign n_w = (wlen_ff == '0) ? WLEN_W'(1) :
                ((32'(wlen_ff) > WINDOW_DEPTH) ? WLEN_W'(WINDOW_DEPTH) : wlen_ff);
   assign slot_in  = (32'(slot_ff) + 32'd1 == 32'(n_w)) ? '0 : slot_ff + 1'b1;
   assign full_pre = count_ff >= n_w;
   assign below    = nc_ff < sum_ff;
   assign mag      = below ? sum_ff - nc_ff : nc_ff - sum_ff;

   bbrs_ram #(.WIDTH(PRICE_W), .DEPTH(WINDOW_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (cmd.update),
      .wr_addr (slot_ff),
      .wr_data (close_ff),
      .rd_addr (slot_ff),
      .rd_data (old_price)
   );

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         MUL_CC: begin mul_a = MUL_A_W'(close_ff);  mul_b = MUL_B_W'(close_ff);  end
         MUL_OO: begin mul_a = MUL_A_W'(old_price); mul_b = MUL_B_W'(old_price); end
         MUL_SS: begin mul_a = MUL_A_W'(sum_ff);    mul_b = MUL_B_W'(sum_ff);    end
         MUL_NQ: begin mul_a = MUL_A_W'(sqsum_ff);  mul_b = MUL_B_W'(n_w);       end
         MUL_NC: begin mul_a = MUL_A_W'(close_ff);  mul_b = MUL_B_W'(n_w);       end
         MUL_MM: begin mul_a = MUL_A_W'(mag);       mul_b = MUL_B_W'(mag);       end
         MUL_M2: begin mul_a = MUL_A_W'(mult_ff);   mul_b = MUL_B_W'(mult_ff);   end
         MUL_VM: begin mul_a = var_ff;              mul_b = MUL_B_W'(m2_ff);     end
         MUL_EF: begin mul_a = MUL_A_W'(equity_ff); mul_b = MUL_B_W'(frac_ff);   end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   bbrs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (cmd.mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod),
      .done  (mul_done)
   );

   bbrs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (cmd.div_go),
      .dividend (dvd_ff),
      .divisor  (close_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   // configuration and window history
   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff  <= WINDOW_LENGTH_RESET;
         mult_ff  <= BAND_MULTIPLIER_RESET;
         frac_ff  <= POSITION_FRACTION_RESET;
         slot_ff  <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
         sqsum_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LENGTH: begin
               wlen_ff  <= csr_wdata[WLEN_W-1:0];
               slot_ff  <= '0;
               count_ff <= '0;
               sum_ff   <= '0;
               sqsum_ff <= '0;
            end
            CSR_BAND_MULTIPLIER:   mult_ff <= csr_wdata[MULT_W-1:0];
            CSR_POSITION_FRACTION: frac_ff <= csr_wdata[FRAC_W-1:0];
            default: ;
         endcase
      end else if (cmd.update) begin
         slot_ff <= slot_in;
         if (full_pre) begin
            sum_ff   <= sum_ff - SUM_W'(old_price) + SUM_W'(close_ff);
            sqsum_ff <= sqsum_ff - SQSUM_W'(sqold_ff) + SQSUM_W'(sqnew_ff);
         end else begin
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_ff + SUM_W'(close_ff);
            sqsum_ff <= sqsum_ff + SQSUM_W'(sqnew_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         close_ff  <= req_close_price;
         bar_ff    <= req_bar_number;
         side_ff   <= req_position_side;
         held_ff   <= req_held_quantity;
         equity_ff <= req_account_equity;
      end
      if (mul_done) begin
         case (cmd.mul_op)
            MUL_CC: sqnew_ff <= prod[2*PRICE_W-1:0];
            MUL_OO: sqold_ff <= prod[2*PRICE_W-1:0];
            MUL_SS: ss_ff    <= prod[VAR_W-1:0];
            MUL_NQ: var_ff   <= prod[VAR_W-1:0] - ss_ff;
            MUL_NC: nc_ff    <= prod[SUM_W-1:0];
            MUL_MM: mm_ff    <= prod[VAR_W-1:0];
            MUL_M2: m2_ff    <= prod[M2_W-1:0];
            MUL_VM: hit_ff   <= RHS_W'({mm_ff, 16'h0}) > prod[RHS_W-1:0];
            MUL_EF: dvd_ff   <= prod[DVD_W+15:16];
            default: ;
         endcase
      end
      if (div_done) begin
         // saturate at the quantity field maximum
         qty_ff <= (|quotient[DVD_W-1:QTY_W]) ? '1 : quotient[QTY_W-1:0];
      end
      if (cmd.out_load) begin
         rsp_order_side       <= cmd.out_sell ? ORDER_SELL : ORDER_BUY;
         rsp_order_quantity   <= cmd.out_sell ? held_ff : qty_ff;
         rsp_order_bar_number <= bar_ff;
      end
   end

   always_comb begin
      status.full_pre   = full_pre;
      status.fill_after = full_pre || (count_ff + 1'b1 == n_w);
      status.mul_done   = mul_done;
      status.div_done   = div_done;
      status.buy  = hit_ff && (var_ff != '0) && below && (side_ff == SIDE_FLAT)
                    && (close_ff != '0);
      status.sell = hit_ff && (var_ff != '0) && !below && (side_ff == SIDE_LONG);
      status.qty_zero = qty_ff == '0;
   end
endmodule

@@ rtl/bbrs_ctrl.sv @@
`include "bollinger_band_reversion_signal_core_defines.svh"
module bbrs_ctrl import bbrs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output cmd_type    cmd,
   input  status_type status
);
   state_type state_ff, state_in;
   logic      sell_ff, sell_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sell_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sell_ff      <= sell_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      sell_in     = sell_ff;
      cmd         = '0;
      cmd.mul_op  = MUL_CC;
      cmd.out_sell = sell_ff;
      req_stall   = state_ff != ST_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_CC;
            end
         end
         ST_CC: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_CC;
            if (status.mul_done) state_in = status.full_pre ? ST_OO : ST_UPDATE;
         end
         ST_OO: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_OO;
            if (status.mul_done) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.fill_after ? ST_SS : ST_IDLE;
         end
         ST_SS: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_SS;
            if (status.mul_done) state_in = ST_NQ;
         end
         ST_NQ: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_NQ;
            if (status.mul_done) state_in = ST_NC;
         end
         ST_NC: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_NC;
            if (status.mul_done) state_in = ST_MM;
         end
         ST_MM: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_MM;
            if (status.mul_done) state_in = ST_M2;
         end
         ST_M2: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_M2;
            if (status.mul_done) state_in = ST_VM;
         end
         ST_VM: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_VM;
            if (status.mul_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.sell) begin
               sell_in  = 1'b1;
               state_in = ST_EMIT;
            end else if (status.buy) begin
               sell_in  = 1'b0;
               state_in = ST_EF;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EF: begin
            cmd.mul_go = 1'b1;
            cmd.mul_op = MUL_EF;
            if (status.mul_done) state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_go = 1'b1;
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // drop a buy that rounds to nothing; hold while the last result is stalled
            if (!sell_ff && status.qty_zero) begin
               state_in = ST_IDLE;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

   `BBRS_ASSERT(a_no_overwrite, clock, reset, cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
   `BBRS_ASSERT(a_mul_done_waited, clock, reset, status.mul_done |-> cmd.mul_go)
   `BBRS_ASSERT(a_div_done_in_divide, clock, reset, status.div_done |-> (state_ff == ST_DIVIDE))
endmodule

@@ rtl/bollinger_band_reversion_signal_core.sv @@
// Bollinger band mean reversion signal.
// Input transaction (req_*): one bar, taken when req_valid is high and req_stall low.
// Result transaction (rsp_*): zero or one market order per bar, taken when rsp_valid
// is high and rsp_stall low. Configuration (csr_*): write window length, band
// multiplier or position fraction by index; csr_ready is always high. Writing the
// window length clears the close history.
// One bar is processed at a time through a shared 62x16 multiplier and a
// one-bit-per-cycle divider; in a buy, the 48-step divide is the largest part of the
// work. req_stall is low only while no bar is in work.
// A finished order sits in an output register; the next bar is taken while it waits.
// If the receiver stalls, the order holds and a following order waits behind it.
// Reset restores the register defaults and clears the history, with no clearing pass.
module bollinger_band_reversion_signal_core import bbrs_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PRICE_W-1:0]    req_close_price,
   input  logic [BAR_W-1:0]      req_bar_number,
   input  logic [SIDE_W-1:0]     req_position_side,
   input  logic [QTY_W-1:0]      req_held_quantity,
   input  logic [EQ_W-1:0]       req_account_equity,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_order_side,
   output logic [QTY_W-1:0]      rsp_order_quantity,
   output logic [BAR_W-1:0]      rsp_order_bar_number,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   bbrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   bbrs_dpath #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .csr_write            (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_close_price      (req_close_price),
      .req_bar_number       (req_bar_number),
      .req_position_side    (req_position_side),
      .req_held_quantity    (req_held_quantity),
      .req_account_equity   (req_account_equity),
      .rsp_order_side       (rsp_order_side),
      .rsp_order_quantity   (rsp_order_quantity),
      .rsp_order_bar_number (rsp_order_bar_number)
   );
endmodule
